// ----- rtl/assert_macros.svh -----
// Assertion macros shared by the RTL files of the base32 decoder.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

`define B32_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

`define B32_ASSERT_NEXT(lbl, clk, rstn, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (pre) |=> (post)) else $error(msg);

`else

`define B32_ASSERT(lbl, clk, rstn, prop, msg)

`define B32_ASSERT_NEXT(lbl, clk, rstn, pre, post, msg)

`endif

`endif

// ----- rtl/b32_pkg.sv -----
// Types and constants shared by the base32 decoder modules.
package b32_pkg;

  localparam int QUEUE_DEPTH = 2;

  localparam logic [7:0] PAD_CHAR = 8'h3D;

  // character classes handed from front to back
  localparam logic [1:0] KIND_SYM = 2'd0;
  localparam logic [1:0] KIND_PAD = 2'd1;
  localparam logic [1:0] KIND_BAD = 2'd2;

  // decode status of the current string
  localparam logic [1:0] ST_RUN  = 2'd0;
  localparam logic [1:0] ST_STOP = 2'd1;
  localparam logic [1:0] ST_ERR  = 2'd2;

  typedef struct packed {
    logic [1:0] kind;
    logic [4:0] sym;
    logic       last;
  } entry_t;

endpackage

// ----- rtl/b32_ifs.sv -----
// Valid/ready stream interfaces for the decoder input and result channels.
interface b32_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  logic       string_end;

  modport source (output valid, output char_code, output string_end, input ready);
  modport sink (input valid, input char_code, input string_end, output ready);
endinterface

interface b32_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_value;
  logic       byte_valid;
  logic       bad_symbol;
  logic       end_of_string;

  modport source (output valid, output byte_value, output byte_valid,
                  output bad_symbol, output end_of_string, input ready);
  modport sink (input valid, input byte_value, input byte_valid,
                input bad_symbol, input end_of_string, output ready);
endinterface

// ----- rtl/base32_stream_decoder.sv -----
// Top level of the streaming base32 decoder: front, queue and back.
//
// Usage: in_ch carries one character per beat (char_code, string_end marks the
// last character of a string). out_ch carries at most one result beat per
// character: a decoded byte, a bad-symbol flag, and end_of_string on the beat
// for the final character. After a bad_symbol beat the consumer discards the
// bytes already received for that string.
// Path: an accepted character is stored in the front-to-back queue, and its
// result beat is then held in the result register.
// Throughput: one character per cycle, sustained while out_ch is ready; the
// back end's accumulator update is the only loop.
// Reset (rst_n low, synchronous) empties the queue, clears the accumulator and
// restarts decoding in the running state.
// When out_ch stalls, the result register holds its beat and the queue absorbs
// up to QUEUE_DEPTH further characters before in_ch.ready drops.
module base32_stream_decoder #(
  parameter int QUEUE_DEPTH = b32_pkg::QUEUE_DEPTH
) (
  input  logic      clk,
  input  logic      rst_n,
  b32_in_if.sink    in_ch,
  b32_out_if.source out_ch
);

  logic            q_push, q_full, q_pop, q_empty;
  b32_pkg::entry_t q_wdata, q_rdata;

  b32_front u_front (
    .in_ch  (in_ch),
    .q_full (q_full),
    .q_push (q_push),
    .q_data (q_wdata)
  );

  b32_fifo #(.DEPTH(QUEUE_DEPTH)) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_wdata),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_rdata),
    .empty     (q_empty)
  );

  b32_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_empty (q_empty),
    .q_data  (q_rdata),
    .q_pop   (q_pop),
    .out_ch  (out_ch)
  );

endmodule

// ----- rtl/b32_front.sv -----
// Front end: accepts characters and classifies them into symbol, pad or bad.
module b32_front (
  b32_in_if.sink          in_ch,
  input  logic            q_full,
  output logic            q_push,
  output b32_pkg::entry_t q_data
);

  logic [7:0] c;

  assign c           = in_ch.char_code;
  assign in_ch.ready = !q_full;
  assign q_push      = in_ch.valid && !q_full;

  always_comb begin
    q_data.last = in_ch.string_end;
    q_data.sym  = 5'd0;
    if (c >= 8'h41 && c <= 8'h5A) begin
      q_data.kind = b32_pkg::KIND_SYM;
      q_data.sym  = 5'(c - 8'h41);
    end else if (c >= 8'h32 && c <= 8'h37) begin
      // '2'..'7' map to 26..31
      q_data.kind = b32_pkg::KIND_SYM;
      q_data.sym  = 5'(c - 8'h18);
    end else if (c == b32_pkg::PAD_CHAR) begin
      q_data.kind = b32_pkg::KIND_PAD;
    end else begin
      q_data.kind = b32_pkg::KIND_BAD;
    end
  end

endmodule

// ----- rtl/b32_fifo.sv -----
// Short queue of classified characters between front and back.
`include "assert_macros.svh"

module b32_fifo #(
  parameter int DEPTH = b32_pkg::QUEUE_DEPTH
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  b32_pkg::entry_t push_data,
  output logic            full,
  input  logic            pop,
  output b32_pkg::entry_t pop_data,
  output logic            empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);

  b32_pkg::entry_t mem_r [DEPTH];
  logic [PW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]   count_r, count_nxt;
  logic            do_push, do_pop;

  assign full     = (count_r == CW'(DEPTH));
  assign empty    = (count_r == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + 1'b1;
    end
    case ({do_push, do_pop})
      2'b10:   count_nxt = count_r + 1'b1;
      2'b01:   count_nxt = count_r - 1'b1;
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  `B32_ASSERT(a_no_underflow, clk, rst_n, !(pop && empty), "pop from empty queue")
  `B32_ASSERT(a_count_bound, clk, rst_n, count_r <= CW'(DEPTH), "queue count overrun")

endmodule

// ----- rtl/b32_back.sv -----
// Back end: bit accumulator, decode status and registered result beat.
`include "assert_macros.svh"

module b32_back (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            q_empty,
  input  b32_pkg::entry_t q_data,
  output logic            q_pop,
  b32_out_if.source       out_ch
);

  logic [11:0] acc_r, acc_nxt;
  logic [2:0]  bits_r, bits_nxt;
  logic [1:0]  status_r, status_nxt;
  logic        out_valid_r;
  logic [7:0]  byte_r;
  logic        byte_valid_r, bad_r, eos_r;

  logic        take;
  logic [11:0] sym_acc;
  logic [3:0]  held5;
  logic [3:0]  held;
  logic        have_byte, bad;
  logic [7:0]  byte_val;

  assign take    = !q_empty && (!out_valid_r || out_ch.ready);
  assign q_pop   = take;
  assign sym_acc = {acc_r[6:0], q_data.sym};
  assign held5   = {1'b0, bits_r} + 4'd5;
  assign held    = held5 - 4'd8;

  always_comb begin
    acc_nxt    = acc_r;
    bits_nxt   = bits_r;
    status_nxt = status_r;
    have_byte  = 1'b0;
    bad        = 1'b0;
    byte_val   = 8'd0;
    if (take) begin
      if (status_r == b32_pkg::ST_RUN) begin
        case (q_data.kind)
          b32_pkg::KIND_SYM: begin
            acc_nxt = sym_acc;
            if (held5 >= 4'd8) begin
              have_byte = 1'b1;
              byte_val  = 8'(sym_acc >> held[2:0]);
              bits_nxt  = held[2:0];
            end else begin
              bits_nxt = held5[2:0];
            end
          end
          b32_pkg::KIND_PAD: status_nxt = b32_pkg::ST_STOP;
          default: begin
            status_nxt = b32_pkg::ST_ERR;
            bad        = 1'b1;
          end
        endcase
      end
      // end of string restarts the decoder
      if (q_data.last) begin
        acc_nxt    = '0;
        bits_nxt   = '0;
        status_nxt = b32_pkg::ST_RUN;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r       <= '0;
      bits_r      <= '0;
      status_r    <= b32_pkg::ST_RUN;
      out_valid_r <= 1'b0;
    end else begin
      acc_r    <= acc_nxt;
      bits_r   <= bits_nxt;
      status_r <= status_nxt;
      if (take) begin
        out_valid_r <= have_byte || bad || q_data.last;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      byte_r       <= byte_val;
      byte_valid_r <= have_byte;
      bad_r        <= bad;
      eos_r        <= q_data.last;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.byte_value    = byte_r;
  assign out_ch.byte_valid    = byte_valid_r;
  assign out_ch.bad_symbol    = bad_r;
  assign out_ch.end_of_string = eos_r;

  `B32_ASSERT_NEXT(a_restart, clk, rst_n, take && q_data.last,
                   bits_r == 3'd0 && acc_r == 12'd0 && status_r == b32_pkg::ST_RUN,
                   "state not cleared after end of string")
  `B32_ASSERT(a_halted_quiet, clk, rst_n,
              !(take && status_r != b32_pkg::ST_RUN && (have_byte || bad)),
              "byte or error after decode stopped")
  `B32_ASSERT(a_bad_no_byte, clk, rst_n, !(out_valid_r && bad_r && byte_valid_r),
              "error beat carries a byte")

endmodule

// ----- verif/base32_decoder_checker.sv -----
// Monitor and result checker for the base32 stream decoder.
`timescale 1ns / 1ps

module base32_decoder_checker (
  input  logic        clk,
  input  logic        rst_n,
  b32_in_if           in_mon,
  b32_out_if          out_mon,
  output int unsigned fail_count,
  output int unsigned backlog
);

  typedef struct packed {
    logic [7:0] byte_value;
    logic       byte_valid;
    logic       bad_symbol;
    logic       end_of_string;
  } decoded_t;

  localparam int REPORT_MAX = 10;

  logic [11:0] acc_bits;
  logic [2:0]  acc_count;
  logic [1:0]  str_status;
  decoded_t    pending_results[$];

  // Advance the decode state by one character; returns 1 when a result beat is due.
  function automatic bit decode_char(input logic [7:0] c, input logic last,
                                     output decoded_t res);
    logic [4:0] sym;
    logic       is_sym;
    logic [3:0] cnt;
    res    = '0;
    is_sym = 1'b0;
    sym    = '0;
    if (c >= 8'h41 && c <= 8'h5A) begin
      is_sym = 1'b1;
      sym    = 5'(c - 8'h41);
    end else if (c >= 8'h32 && c <= 8'h37) begin
      is_sym = 1'b1;
      sym    = 5'(c - 8'h32 + 8'd26);
    end
    if (str_status == b32_pkg::ST_RUN) begin
      if (c == b32_pkg::PAD_CHAR) begin
        str_status = b32_pkg::ST_STOP;
      end else if (!is_sym) begin
        str_status     = b32_pkg::ST_ERR;
        res.bad_symbol = 1'b1;
      end else begin
        cnt      = {1'b0, acc_count} + 4'd5;
        acc_bits = {acc_bits[6:0], sym};
        if (cnt >= 4'd8) begin
          cnt            = cnt - 4'd8;
          res.byte_value = 8'(acc_bits >> cnt);
          res.byte_valid = 1'b1;
        end
        acc_count = cnt[2:0];
      end
    end
    if (last) begin
      acc_bits   = '0;
      acc_count  = '0;
      str_status = b32_pkg::ST_RUN;
    end
    res.end_of_string = last;
    return res.byte_valid || res.bad_symbol || last;
  endfunction

  initial begin
    fail_count = 0;
    backlog    = 0;
    acc_bits   = '0;
    acc_count  = '0;
    str_status = b32_pkg::ST_RUN;
  end

  always @(posedge clk) begin
    decoded_t got;
    decoded_t want;
    decoded_t res;
    if (!rst_n) begin
      acc_bits   = '0;
      acc_count  = '0;
      str_status = b32_pkg::ST_RUN;
      pending_results.delete();
    end else begin
      // results never leave in the same cycle their character is accepted, so check before predicting
      if (out_mon.valid && out_mon.ready) begin
        got = '{out_mon.byte_value, out_mon.byte_valid, out_mon.bad_symbol,
                out_mon.end_of_string};
        if (pending_results.size() == 0) begin
          if (fail_count < REPORT_MAX)
            $display("%0t: unexpected result beat: byte=%02h bv=%0b bad=%0b eos=%0b",
                     $realtime, got.byte_value, got.byte_valid, got.bad_symbol,
                     got.end_of_string);
          fail_count++;
        end else begin
          want = pending_results.pop_front();
          if (got !== want) begin
            if (fail_count < REPORT_MAX)
              $display("%0t: mismatch: exp %02h/%0b/%0b/%0b got %02h/%0b/%0b/%0b",
                       $realtime, want.byte_value, want.byte_valid, want.bad_symbol,
                       want.end_of_string, got.byte_value, got.byte_valid,
                       got.bad_symbol, got.end_of_string);
            fail_count++;
          end
        end
      end
      if (in_mon.valid && in_mon.ready) begin
        if (decode_char(in_mon.char_code, in_mon.string_end, res))
          pending_results.push_back(res);
      end
    end
    backlog = pending_results.size();
  end

endmodule

// ----- verif/testbench.sv -----
// Stimulus, flow control and verdict for the base32 stream decoder test.
`timescale 1ns / 1ps

module testbench;
  localparam int RESET_CYCLES = 10;
  localparam int RANDOM_CHARS = 1800;
  localparam int HOLD_AT      = 700;
  localparam int HOLD_CYCLES  = 600;
  localparam int IDLE_LIMIT   = 4000;
  localparam int DRAIN_CYCLES = 10;

  logic        clk;
  logic        rst_n;
  int unsigned fail_count;
  int unsigned backlog;
  int          chars_sent;
  bit          hold_req;
  int          idle_cycles;

  b32_in_if  in_if ();
  b32_out_if out_if ();

  base32_stream_decoder dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if),
    .out_ch (out_if)
  );

  base32_decoder_checker decode_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_mon     (in_if),
    .out_mon    (out_if),
    .fail_count (fail_count),
    .backlog    (backlog)
  );

  initial clk = 1'b0;
  always #10 clk = ~clk;

  // mostly short gaps, now and then a long one
  function automatic int gap_len();
    if ($urandom_range(0, 9) == 0)
      return $urandom_range(10, 40);
    return $urandom_range(1, 3);
  endfunction

  function automatic logic [7:0] sym_char(input int v);
    if (v < 26)
      return 8'(8'h41 + v);
    return 8'(8'h32 + v - 26);
  endfunction

  // sender-side idling state
  bit send_calm;
  int send_calm_left;

  task automatic send_char(input logic [7:0] c, input logic last);
    int gap;
    gap = 0;
    if (send_calm_left == 0) begin
      send_calm      = ($urandom_range(0, 3) == 0);
      send_calm_left = $urandom_range(20, 120);
    end
    send_calm_left--;
    if (!send_calm && $urandom_range(0, 2) == 0)
      gap = gap_len();
    repeat (gap) begin
      @(negedge clk);
      in_if.valid <= 1'b0;
    end
    @(negedge clk);
    in_if.valid      <= 1'b1;
    in_if.char_code  <= c;
    in_if.string_end <= last;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    chars_sent++;
    if (chars_sent == HOLD_AT)
      hold_req = 1'b1;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++)
      send_char(s[i], i == s.len() - 1);
  endtask

  // one random string: mostly well-formed symbol runs, some broken or noisy
  task automatic send_random_string();
    logic [7:0] chars[$];
    int n;
    int kind;
    kind = $urandom_range(0, 99);
    if (kind < 70) begin
      n = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 24) : $urandom_range(1, 10);
      for (int i = 0; i < n; i++)
        chars.push_back(sym_char($urandom_range(0, 31)));
      if ($urandom_range(0, 1) == 0)
        while (chars.size() % 8 != 0) chars.push_back(8'h3D);
      // trailing junk, ignored by the decoder when padding precedes it
      if ($urandom_range(0, 4) == 0)
        repeat ($urandom_range(1, 3)) chars.push_back(8'($urandom_range(0, 255)));
    end else if (kind < 85) begin
      // well-formed run broken by one stray byte
      n = $urandom_range(2, 12);
      for (int i = 0; i < n; i++)
        chars.push_back(sym_char($urandom_range(0, 31)));
      chars[$urandom_range(0, n - 1)] = 8'($urandom_range(0, 255));
    end else begin
      n = $urandom_range(1, 6);
      for (int i = 0; i < n; i++)
        chars.push_back(8'($urandom_range(0, 255)));
    end
    foreach (chars[i])
      send_char(chars[i], i == chars.size() - 1);
  endtask

  // receiver: random stalls, calm stretches, and one long hold-off
  initial begin
    int  stall_left;
    int  hold_left;
    int  calm_left;
    bit  calm;
    bit  hold_done;
    logic nxt;
    stall_left   = 0;
    hold_left    = 0;
    calm_left    = 0;
    calm         = 1'b0;
    hold_done    = 1'b0;
    out_if.ready = 1'b0;
    wait (rst_n);
    forever begin
      @(negedge clk);
      if (hold_req && !hold_done) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (calm_left == 0) begin
        calm      = ($urandom_range(0, 3) == 0);
        calm_left = $urandom_range(50, 300);
      end
      calm_left--;
      if (hold_left > 0) begin
        hold_left--;
        nxt = 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        nxt = 1'b0;
      end else if (!calm && $urandom_range(0, 3) == 0) begin
        stall_left = gap_len() - 1;
        nxt        = 1'b0;
      end else begin
        nxt = 1'b1;
      end
      out_if.ready <= nxt;
    end
  end

  // watchdog on handshake progress
  initial idle_cycles = 0;
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("testbench: FAIL");
        $finish;
      end
    end
  end

  initial begin
    in_if.valid      = 1'b0;
    in_if.char_code  = '0;
    in_if.string_end = 1'b0;
    rst_n            = 1'b0;
    chars_sent       = 0;
    hold_req         = 1'b0;
    send_calm        = 1'b0;
    send_calm_left   = 0;
    repeat (RESET_CYCLES) @(negedge clk);
    rst_n <= 1'b1;

    // directed strings
    send_text("MZXW6===");           // padding stops decode
    send_text("77777777");           // all-ones symbols, five 0xFF bytes
    send_text("a");                  // lower case on the last character
    // NUL is bad, later chars ignored
    send_char(8'h41, 1'b0);
    send_char(8'h42, 1'b0);
    send_char(8'h00, 1'b0);
    send_char(8'h3D, 1'b1);
    send_char(8'hFF, 1'b1);          // top byte value, alone
    send_text("=");                  // padding as the whole string
    send_text("A");                  // leftover bits dropped
    send_text("@[18");               // neighbors of the alphabet ranges

    while (chars_sent < RANDOM_CHARS) send_random_string();

    @(negedge clk);
    in_if.valid <= 1'b0;
    while (backlog != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (fail_count == 0)
      $display("testbench: PASS");
    else
      $display("testbench: FAIL");
    $finish;
  end

endmodule

// ----- files.f -----
+incdir+rtl
rtl/b32_pkg.sv
rtl/b32_ifs.sv
rtl/b32_front.sv
rtl/b32_fifo.sv
rtl/b32_back.sv
rtl/base32_stream_decoder.sv
verif/base32_decoder_checker.sv
verif/testbench.sv
